// ----- src/block_cache_tag_store_lru_assert.svh -----
// assertion macros for the block cache tag store
// expects clk and rst_n in the scope of the module that includes it
`ifndef BLOCK_CACHE_TAG_STORE_LRU_ASSERT_SVH
`define BLOCK_CACHE_TAG_STORE_LRU_ASSERT_SVH

// property that holds at every clock edge out of reset
`define BCT_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BCT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bctsl_pkg.sv -----
// shared types and codes for the block cache tag store
// no dependencies
`timescale 1ns / 1ps

package bctsl_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int BLOCK_BITS_DEF = 48;

  localparam int OP_W    = 3;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 48;
  localparam int STAMP_W = 48;
  localparam int CNT_W   = 32;
  localparam int STAT_W  = 2;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int DTOT_W  = 5;

  localparam logic [OP_W-1:0] OP_GET_RD = 3'd0;
  localparam logic [OP_W-1:0] OP_GET_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
  localparam logic [OP_W-1:0] OP_WB     = 3'd3;
  localparam logic [OP_W-1:0] OP_INVAL  = 3'd4;
  localparam logic [OP_W-1:0] OP_SYNC   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_DEV   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WB   = 2'd2;

  localparam logic [DEV_W-1:0] DEV_NONE = 8'd0;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [DEV_W-1:0] device_id;
    logic [BLK_W-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot_index;
    logic [DEV_W-1:0]  out_device;
    logic [BLK_W-1:0]  out_block;
    logic              last;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [DTOT_W-1:0] dirty_total;
  } out_item_t;

endpackage

// ----- src/bctsl_ram.sv -----
// generic single write port ram with registered read
// depends on bctsl_pkg for default sizes
`timescale 1ns / 1ps

module bctsl_ram import bctsl_pkg::*; #(
  parameter int WIDTH = DEV_W + BLK_W + STAMP_W,
  parameter int DEPTH = ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/block_cache_tag_store_lru.sv -----
// channel  | ports                           | moves
// input    | in_valid in_stall in_data       | one request transaction
// result   | out_valid out_stall out_payload | one result, one or more for sync
//
// a request walks the tag ram one slot per cycle through a single read port and
// one stamp comparator; an early hit ends the walk
// a sync pauses the walk at every dirty slot until the output register is free for its writeback result
// requests with device zero and an operation up to writeback, or with an unused code, skip the walk
// reset clears valid and dirty bits, counters and the use clock at once
// in_stall is high from acceptance until the last result is in the output register
// uses bctsl_pkg, bctsl_ram and the assertion macro header
`timescale 1ns / 1ps

module block_cache_tag_store_lru import bctsl_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SB = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
  localparam int RW = DEV_W + SB + STAMP_W;
  localparam logic [IW:0] LAST_IDX  = (IW+1)'(ENTRIES - 1);
  localparam logic [IW:0] ENTRY_NUM = (IW+1)'(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_SEMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [DEV_W-1:0]   dev_r, dev_nxt;
  logic [SB-1:0]      blk_r, blk_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;
  logic [CW-1:0]      dcnt_r, dcnt_nxt;
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   misses_r, misses_nxt;
  logic [IW:0]        rd_idx_r, rd_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [DEV_W-1:0]   hit_dev_r, hit_dev_nxt;
  logic [SB-1:0]      hit_blk_r, hit_blk_nxt;
  logic               inv_found_r, inv_found_nxt;
  logic [IW-1:0]      inv_idx_r, inv_idx_nxt;
  logic               best_found_r, best_found_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic               out_valid_r;
  out_item_t          out_payload_r, out_nxt;
  logic               out_load;
  logic               out_free;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [RW-1:0]      ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [RW-1:0]      ram_rdata;
  logic [DEV_W-1:0]   rd_dev;
  logic [SB-1:0]      rd_blk;
  logic [STAMP_W-1:0] rd_stamp;

  bctsl_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_dev   = ram_rdata[RW-1 -: DEV_W];
  assign rd_blk   = ram_rdata[STAMP_W +: SB];
  assign rd_stamp = ram_rdata[STAMP_W-1:0];

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    logic               e_v;
    logic               e_d;
    logic               more;
    logic               reject;
    logic               touch;
    logic [IW-1:0]      touch_idx;
    logic [IW-1:0]      vic;
    logic [STAMP_W-1:0] tick;

    state_nxt      = state_r;
    op_nxt         = op_r;
    dev_nxt        = dev_r;
    blk_nxt        = blk_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    dcnt_nxt       = dcnt_r;
    use_clock_nxt  = use_clock_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = rd_vld_r;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_dev_nxt    = hit_dev_r;
    hit_blk_nxt    = hit_blk_r;
    inv_found_nxt  = inv_found_r;
    inv_idx_nxt    = inv_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    out_nxt        = out_payload_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    e_v            = 1'b0;
    e_d            = 1'b0;
    more           = 1'b0;
    touch          = 1'b0;
    touch_idx      = '0;
    vic            = '0;
    tick           = use_clock_r + STAMP_W'(1);
    reject         = (op_r <= OP_WB) && (dev_r == DEV_NONE);

    // any dirty slot beyond the one being written back
    for (int i = 0; i < ENTRIES; i++) begin
      if ((IW+1)'(i) > {1'b0, hit_idx_r} && dirty_r[i]) begin
        more = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.operation;
          dev_nxt        = in_data.device_id;
          blk_nxt        = in_data.block_number[SB-1:0];
          rd_idx_nxt     = '0;
          rd_vld_nxt     = 1'b0;
          hit_nxt        = 1'b0;
          inv_found_nxt  = 1'b0;
          best_found_nxt = 1'b0;
          if (in_data.operation == OP_SYNC ||
              (in_data.operation <= OP_INVAL &&
               !(in_data.operation <= OP_WB && in_data.device_id == DEV_NONE))) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_SCAN: begin
        if (rd_idx_r < ENTRY_NUM) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + (IW+1)'(1);
          rd_vld_nxt  = 1'b1;
          chk_idx_nxt = rd_idx_r[IW-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          e_v = valid_r[chk_idx_r];
          e_d = dirty_r[chk_idx_r];
          if (op_r == OP_SYNC) begin
            if (e_v && e_d) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = chk_idx_r;
              hit_dev_nxt = rd_dev;
              hit_blk_nxt = rd_blk;
              rd_vld_nxt  = 1'b0;
              state_nxt   = S_SEMIT;
            end else if ({1'b0, chk_idx_r} == LAST_IDX) begin
              state_nxt = S_FIN;
            end
          end else if (e_v && rd_dev == dev_r && rd_blk == blk_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_idx_r;
            rd_vld_nxt  = 1'b0;
            state_nxt   = S_FIN;
          end else begin
            // replacement choice: first free slot, else oldest clean slot
            if (!e_v) begin
              if (!inv_found_r) begin
                inv_found_nxt = 1'b1;
                inv_idx_nxt   = chk_idx_r;
              end
            end else if (!e_d && (!best_found_r || rd_stamp < best_stamp_r)) begin
              best_found_nxt = 1'b1;
              best_idx_nxt   = chk_idx_r;
              best_stamp_nxt = rd_stamp;
            end
            if ({1'b0, chk_idx_r} == LAST_IDX) begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_SEMIT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.status        = ST_OK;
          out_nxt.action        = ACT_WB;
          out_nxt.slot_index    = SLOT_W'(hit_idx_r);
          out_nxt.out_device    = hit_dev_r;
          out_nxt.out_block     = BLK_W'(hit_blk_r);
          out_nxt.last          = !more;
          out_nxt.hit_total     = hits_r;
          out_nxt.miss_total    = misses_r;
          out_nxt.dirty_total   = '0;
          dirty_nxt[hit_idx_r]  = 1'b0;
          dcnt_nxt              = dcnt_r - CW'(1);
          if (more) begin
            rd_idx_nxt = {1'b0, hit_idx_r} + (IW+1)'(1);
            rd_vld_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load           = 1'b1;
          state_nxt          = S_IDLE;
          out_nxt.status     = ST_OK;
          out_nxt.action     = ACT_NONE;
          out_nxt.slot_index = '0;
          out_nxt.out_device = '0;
          out_nxt.out_block  = '0;
          out_nxt.last       = 1'b1;
          if (reject) begin
            out_nxt.status = ST_BAD_DEV;
          end else begin
            case (op_r) inside
              OP_GET_RD, OP_GET_WR: begin
                if (hit_r) begin
                  hits_nxt           = hits_r + CNT_W'(1);
                  touch              = 1'b1;
                  touch_idx          = hit_idx_r;
                  out_nxt.slot_index = SLOT_W'(hit_idx_r);
                  if (op_r == OP_GET_WR && !dirty_r[hit_idx_r]) begin
                    dirty_nxt[hit_idx_r] = 1'b1;
                    dcnt_nxt             = dcnt_r + CW'(1);
                  end
                end else begin
                  misses_nxt = misses_r + CNT_W'(1);
                  if (inv_found_r || best_found_r) begin
                    vic                = inv_found_r ? inv_idx_r : best_idx_r;
                    touch              = 1'b1;
                    touch_idx          = vic;
                    valid_nxt[vic]     = 1'b1;
                    dirty_nxt[vic]     = (op_r == OP_GET_WR);
                    if (op_r == OP_GET_WR) begin
                      dcnt_nxt = dcnt_r + CW'(1);
                    end
                    out_nxt.action     = ACT_FILL;
                    out_nxt.slot_index = SLOT_W'(vic);
                    out_nxt.out_device = dev_r;
                    out_nxt.out_block  = BLK_W'(blk_r);
                  end else begin
                    out_nxt.status = ST_NO_SPACE;
                  end
                end
              end
              OP_MARK: begin
                if (hit_r) begin
                  touch              = 1'b1;
                  touch_idx          = hit_idx_r;
                  out_nxt.slot_index = SLOT_W'(hit_idx_r);
                  if (!dirty_r[hit_idx_r]) begin
                    dirty_nxt[hit_idx_r] = 1'b1;
                    dcnt_nxt             = dcnt_r + CW'(1);
                  end
                end else begin
                  out_nxt.status = ST_NOT_FOUND;
                end
              end
              OP_WB: begin
                if (hit_r) begin
                  touch     = 1'b1;
                  touch_idx = hit_idx_r;
                  if (dirty_r[hit_idx_r]) begin
                    dirty_nxt[hit_idx_r] = 1'b0;
                    dcnt_nxt             = dcnt_r - CW'(1);
                    out_nxt.action       = ACT_WB;
                    out_nxt.slot_index   = SLOT_W'(hit_idx_r);
                    out_nxt.out_device   = dev_r;
                    out_nxt.out_block    = BLK_W'(blk_r);
                  end
                end
              end
              OP_INVAL: begin
                if (hit_r) begin
                  touch                = 1'b1;
                  touch_idx            = hit_idx_r;
                  valid_nxt[hit_idx_r] = 1'b0;
                  dirty_nxt[hit_idx_r] = 1'b0;
                  if (dirty_r[hit_idx_r]) begin
                    dcnt_nxt = dcnt_r - CW'(1);
                  end
                  out_nxt.slot_index = SLOT_W'(hit_idx_r);
                end else begin
                  out_nxt.status = ST_NOT_FOUND;
                end
              end
              default: begin
                out_nxt.action = ACT_NONE;
              end
            endcase
          end
          // every lookup hit or allocation advances the use clock and restamps the slot
          if (touch) begin
            use_clock_nxt = tick;
            ram_we        = 1'b1;
            ram_waddr     = touch_idx;
            ram_wdata     = {dev_r, blk_r, tick};
          end
          out_nxt.hit_total   = hits_nxt;
          out_nxt.miss_total  = misses_nxt;
          out_nxt.dirty_total = DTOT_W'(dcnt_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      dcnt_r      <= '0;
      use_clock_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      dcnt_r      <= dcnt_nxt;
      use_clock_r <= use_clock_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dev_r        <= dev_nxt;
    blk_r        <= blk_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_dev_r    <= hit_dev_nxt;
    hit_blk_r    <= hit_blk_nxt;
    inv_found_r  <= inv_found_nxt;
    inv_idx_r    <= inv_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    if (out_load) begin
      out_payload_r <= out_nxt;
    end
  end

`include "block_cache_tag_store_lru_assert.svh"

  `BCT_CHECK(a_dcnt_tracks, dcnt_r == CW'($countones(dirty_r)), "dirty count out of step")
  `BCT_CHECK(a_dirty_valid, (dirty_r & ~valid_r) == '0, "dirty bit on an invalid slot")
  `BCT_IMPLY(a_last_idle, out_load && out_nxt.last, state_r == S_IDLE, "busy after last result")
  `BCT_IMPLY(a_accept_go, in_valid && !in_stall, state_r == S_SCAN || state_r == S_FIN,
    "accepted request not started")

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the block cache tag store with lru replacement
// holds its own model of the tag store; depends on bctsl_pkg and block_cache_tag_store_lru
`timescale 1ns / 1ps

module testbench;
  import bctsl_pkg::*;

  localparam int NSLOT     = ENTRIES_DEF;
  localparam int NKEYS     = 24;
  localparam int LIMIT     = 400000;
  localparam int TAIL_WAIT = 64;

  // codes outside the defined operation set
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_payload;

  // model of the tag store
  logic              slot_valid [NSLOT];
  logic              slot_dirty [NSLOT];
  logic [DEV_W-1:0]  slot_dev   [NSLOT];
  logic [BLK_W-1:0]  slot_blk   [NSLOT];
  logic [STAMP_W-1:0] slot_stamp [NSLOT];
  logic [STAMP_W-1:0] use_ctr;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  out_item_t pending_resp[$];

  logic [DEV_W-1:0] key_dev [NKEYS];
  logic [BLK_W-1:0] key_blk [NKEYS];

  int err_count;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;

  block_cache_tag_store_lru u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // lookup refreshes the stamp of a matching slot
  function automatic int find_entry(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_valid[i] && slot_dev[i] == dev && slot_blk[i] == blk) begin
        use_ctr = use_ctr + 1'b1;
        slot_stamp[i] = use_ctr;
        return i;
      end
    end
    return -1;
  endfunction

  // first free slot, else oldest clean one, lowest index on ties
  function automatic int pick_victim();
    int best;
    logic [STAMP_W-1:0] best_stamp;
    best = -1;
    best_stamp = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!slot_valid[i]) return i;
      if (!slot_dirty[i] && (best < 0 || slot_stamp[i] < best_stamp)) begin
        best_stamp = slot_stamp[i];
        best = i;
      end
    end
    return best;
  endfunction

  function automatic out_item_t make_resp(input logic [STAT_W-1:0] st,
                                          input logic [ACT_W-1:0] act, input int slot,
                                          input logic [DEV_W-1:0] dev,
                                          input logic [BLK_W-1:0] blk);
    out_item_t r;
    r = '0;
    r.status     = st;
    r.action     = act;
    r.slot_index = (slot < 0) ? '0 : SLOT_W'(slot);
    r.out_device = dev;
    r.out_block  = blk;
    r.hit_total  = hit_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  task automatic predict_cache_response(input in_item_t req);
    out_item_t batch[$];
    int s;
    logic [DTOT_W-1:0] ndirty;
    if (req.operation <= OP_WB && req.device_id == DEV_NONE) begin
      batch.push_back(make_resp(ST_BAD_DEV, ACT_NONE, -1, '0, '0));
    end else begin
      case (req.operation)
        OP_GET_RD, OP_GET_WR: begin
          s = find_entry(req.device_id, req.block_number);
          if (s >= 0) begin
            if (req.operation == OP_GET_WR) slot_dirty[s] = 1'b1;
            hit_cnt = hit_cnt + 1'b1;
            batch.push_back(make_resp(ST_OK, ACT_NONE, s, '0, '0));
          end else begin
            miss_cnt = miss_cnt + 1'b1;
            s = pick_victim();
            if (s < 0) begin
              batch.push_back(make_resp(ST_NO_SPACE, ACT_NONE, -1, '0, '0));
            end else begin
              slot_dev[s]   = req.device_id;
              slot_blk[s]   = req.block_number;
              slot_valid[s] = 1'b1;
              slot_dirty[s] = (req.operation == OP_GET_WR);
              use_ctr       = use_ctr + 1'b1;
              slot_stamp[s] = use_ctr;
              batch.push_back(make_resp(ST_OK, ACT_FILL, s, req.device_id, req.block_number));
            end
          end
        end
        OP_MARK: begin
          s = find_entry(req.device_id, req.block_number);
          if (s >= 0) begin
            slot_dirty[s] = 1'b1;
            batch.push_back(make_resp(ST_OK, ACT_NONE, s, '0, '0));
          end else begin
            batch.push_back(make_resp(ST_NOT_FOUND, ACT_NONE, -1, '0, '0));
          end
        end
        OP_WB: begin
          s = find_entry(req.device_id, req.block_number);
          if (s >= 0 && slot_dirty[s]) begin
            slot_dirty[s] = 1'b0;
            batch.push_back(make_resp(ST_OK, ACT_WB, s, slot_dev[s], slot_blk[s]));
          end else begin
            batch.push_back(make_resp(ST_OK, ACT_NONE, -1, '0, '0));
          end
        end
        OP_INVAL: begin
          s = find_entry(req.device_id, req.block_number);
          if (s >= 0) begin
            slot_valid[s] = 1'b0;
            slot_dirty[s] = 1'b0;
            batch.push_back(make_resp(ST_OK, ACT_NONE, s, '0, '0));
          end else begin
            batch.push_back(make_resp(ST_NOT_FOUND, ACT_NONE, -1, '0, '0));
          end
        end
        OP_SYNC: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_valid[i] && slot_dirty[i]) begin
              slot_dirty[i] = 1'b0;
              batch.push_back(make_resp(ST_OK, ACT_WB, i, slot_dev[i], slot_blk[i]));
            end
          end
          if (batch.size() == 0) batch.push_back(make_resp(ST_OK, ACT_NONE, -1, '0, '0));
        end
        default: begin
          batch.push_back(make_resp(ST_OK, ACT_NONE, -1, '0, '0));
        end
      endcase
    end
    ndirty = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_valid[i] && slot_dirty[i]) ndirty = ndirty + 1'b1;
    end
    foreach (batch[k]) begin
      batch[k].dirty_total = ndirty;
      batch[k].last        = (k == batch.size() - 1);
      pending_resp.push_back(batch[k]);
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        $error("result transaction with nothing expected: %0h", out_payload);
        err_count++;
      end else begin
        want = pending_resp.pop_front();
        check_field("status",      want.status,      out_payload.status);
        check_field("action",      want.action,      out_payload.action);
        check_field("slot_index",  want.slot_index,  out_payload.slot_index);
        check_field("out_device",  want.out_device,  out_payload.out_device);
        check_field("out_block",   want.out_block,   out_payload.out_block);
        check_field("last",        want.last,        out_payload.last);
        check_field("hit_total",   want.hit_total,   out_payload.hit_total);
        check_field("miss_total",  want.miss_total,  out_payload.miss_total);
        check_field("dirty_total", want.dirty_total, out_payload.dirty_total);
      end
    end
  end

  // valid stays high after acceptance so back-to-back requests never toggle it
  task automatic send_req(input logic [OP_W-1:0] op, input logic [DEV_W-1:0] dev,
                          input logic [BLK_W-1:0] blk);
    in_item_t req;
    int gap;
    req.operation    = op;
    req.device_id    = dev;
    req.block_number = blk;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cache_response(req);
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic wait_for_results();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (n < 40000 && pending_resp.size() != 0) begin
      @(posedge clk);
      n++;
    end
    if (pending_resp.size() != 0) begin
      $error("%0d expected results never arrived", pending_resp.size());
      err_count++;
      pending_resp.delete();
    end
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(OP_GET_RD,  DEV_NONE, '1);
    send_req(OP_GET_WR,  DEV_NONE, '0);
    send_req(OP_MARK,    DEV_NONE, '0);
    send_req(OP_WB,      DEV_NONE, '1);
    send_req(OP_INVAL,   DEV_NONE, '0);
    send_req(OP_SYNC,    DEV_NONE, '0);
    send_req(OP_GET_RD,  8'hFF, '1);
    send_req(OP_GET_RD,  8'hFF, '1);
    send_req(OP_WB,      8'hFF, '1);
    send_req(OP_GET_WR,  8'hFF, '1);
    send_req(OP_WB,      8'hFF, '1);
    send_req(OP_MARK,    8'hFF, '1);
    send_req(OP_MARK,    8'h01, '0);
    send_req(OP_WB,      8'h01, '0);
    send_req(OP_GET_WR,  8'h01, '0);
    send_req(OP_GET_RD,  8'h80, 48'h8000_0000_0000);
    send_req(OP_SYNC,    8'h01, '0);
    send_req(OP_SYNC,    8'h01, '0);
    send_req(OP_INVAL,   8'hFF, '1);
    send_req(OP_INVAL,   8'hFF, '1);
    send_req(OP_SPARE_6, 8'h55, 48'h5555_5555_5555);
    send_req(OP_SPARE_7, DEV_NONE, '1);
    send_req(OP_GET_RD,  8'h01, 48'h1);
    wait_for_results();
  endtask

  // every slot dirty, then sync of all sixteen, then lru order among clean slots
  task automatic test_all_dirty_and_lru();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    for (int i = 0; i < NSLOT; i++) send_req(OP_GET_WR, 8'h2A, BLK_W'(i));
    send_req(OP_GET_RD, 8'h2A, 48'hABC);
    send_req(OP_GET_WR, 8'h2B, 48'h0);
    send_req(OP_MARK,   8'h2A, 48'h3);
    send_req(OP_SYNC,   8'h2A, 48'h0);
    send_req(OP_GET_RD, 8'h2A, 48'h5);
    send_req(OP_GET_RD, 8'h2A, 48'h0);
    send_req(OP_GET_RD, 8'h2A, 48'h9);
    for (int i = 0; i < 4; i++) send_req(OP_GET_RD, 8'h3C, BLK_W'(i));
    send_req(OP_MARK,   8'h3C, 48'h1);
    send_req(OP_GET_RD, 8'h3D, 48'h7);
    send_req(OP_SYNC,   8'h3C, 48'h0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int pick;
    int k;
    logic [OP_W-1:0]  op;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      k    = $urandom_range(NKEYS - 1);
      dev  = key_dev[k];
      blk  = key_blk[k];
      if (pick < 30) op = OP_GET_RD;
      else if (pick < 50) op = OP_GET_WR;
      else if (pick < 62) op = OP_MARK;
      else if (pick < 74) op = OP_WB;
      else if (pick < 84) op = OP_INVAL;
      else if (pick < 92) op = OP_SYNC;
      else begin
        // noise: any code, any device including none, any block
        op  = OP_W'($urandom_range(7));
        dev = ($urandom_range(3) == 0) ? DEV_NONE : DEV_W'($urandom_range(255));
        blk = BLK_W'({$urandom(), $urandom()});
      end
      send_req(op, dev, blk);
    end
    wait_for_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    err_count      = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_dev[i]   = '0;
      slot_blk[i]   = '0;
      slot_stamp[i] = '0;
    end
    use_ctr  = '0;
    hit_cnt  = '0;
    miss_cnt = '0;
    for (int i = 0; i < NKEYS; i++) begin
      key_dev[i] = DEV_W'($urandom_range(255, 1));
      key_blk[i] = BLK_W'({$urandom(), $urandom()});
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_all_dirty_and_lru();
    test_random_traffic(40, 0, 0);
    test_random_traffic(40, 61, 0);
    test_random_traffic(40, 0, 61);
    test_random_traffic(40, 12, 12);

    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/bctsl_pkg.sv
src/bctsl_ram.sv
src/block_cache_tag_store_lru.sv
tb/testbench.sv
